>>> src/uer_pkg.sv
// Shared types and codes for the ultrasonic echo ranger.
`default_nettype none

package uer_pkg;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned IDLE_W     = 16;
    localparam int unsigned WIDTH_W    = 10;
    localparam int unsigned DIST_W     = 13;
    localparam int unsigned OP_W       = 2;

    typedef enum logic [OP_W-1:0] {
        OP_TICK    = 2'd0,
        OP_ENABLE  = 2'd1,
        OP_DISABLE = 2'd2,
        OP_NONE    = 2'd3
    } uer_op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IDLE_LIMIT      = 2'd0,
        CFG_MAX_WIDTH       = 2'd1,
        CFG_DISTANCE_OFFSET = 2'd2,
        CFG_UNUSED          = 2'd3
    } uer_cfg_idx_t;

    localparam logic [IDLE_W-1:0]  IDLE_LIMIT_RST      = 16'd60000;
    localparam logic [WIDTH_W-1:0] MAX_WIDTH_RST       = 10'd1000;
    localparam logic [WIDTH_W-1:0] DISTANCE_OFFSET_RST = 10'd200;

    typedef enum logic [5:0] {
        PH_START    = 6'b000001,
        PH_READY    = 6'b000010,
        PH_TRIGGER  = 6'b000100,
        PH_WAITING  = 6'b001000,
        PH_RAISED   = 6'b010000,
        PH_FINISHED = 6'b100000
    } uer_phase_t;

    typedef struct packed {
        uer_phase_t         phase;
        logic [IDLE_W-1:0]  idle_count;
        logic [WIDTH_W-1:0] width_count;
        logic [WIDTH_W-1:0] last_width;
        logic [DIST_W-1:0]  last_distance;
        logic               trigger_out;
        logic               run_flag;
    } uer_state_t;

    typedef struct packed {
        logic [IDLE_W-1:0]  idle_limit;
        logic [WIDTH_W-1:0] max_width;
        logic [WIDTH_W-1:0] distance_offset;
    } uer_cfg_t;

    typedef struct packed {
        logic               trigger_level;
        logic               done_res;
        logic [DIST_W-1:0]  distance;
        logic [WIDTH_W-1:0] measured_width;
        logic               running;
    } uer_result_t;

endpackage

`default_nettype wire

>>> src/uer_if.sv
// Valid/ready channel interfaces for tick items and ranging results.
`default_nettype none

interface uer_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic       echo_level;

    modport source (output valid, output op, output echo_level, input ready);
    modport sink   (input valid, input op, input echo_level, output ready);
endinterface

interface uer_out_if;
    logic        valid;
    logic        ready;
    logic        trigger_level;
    logic        done_res;
    logic [12:0] distance;
    logic [9:0]  measured_width;
    logic        running;

    modport source (output valid, output trigger_level, output done_res, output distance,
                    output measured_width, output running, input ready);
    modport sink   (input valid, input trigger_level, input done_res, input distance,
                    input measured_width, input running, output ready);
endinterface

`default_nettype wire

>>> src/uer_step.sv
// Next-state logic of the ranging sequencer for one item.
`default_nettype none

module uer_step (
    input  uer_pkg::uer_state_t            cur,
    input  uer_pkg::uer_cfg_t              cfg,
    input  logic [uer_pkg::OP_W-1:0]       op,
    input  logic                           echo_level,
    output uer_pkg::uer_state_t            nxt,
    output logic                           done
);
    import uer_pkg::*;

    // floor(w*34/10) + offset; the divide by ten is a reciprocal multiply,
    // exact for all 16-bit dividends.
    function automatic logic [DIST_W-1:0] calc_distance(
        input logic [WIDTH_W-1:0] w,
        input logic [WIDTH_W-1:0] off
    );
        logic [15:0] scaled;
        logic [31:0] prod;
        begin
            scaled = 16'({w, 5'b0}) + 16'({w, 1'b0});
            prod   = {16'b0, scaled} * 32'd52429;
            calc_distance = prod[31:19] + DIST_W'(off);
        end
    endfunction

    logic [WIDTH_W-1:0] width_inc;

    assign width_inc = cur.width_count + 10'd1;

    always_comb
    begin
        nxt  = cur;
        done = 1'b0;
        case (uer_op_t'(op))
            OP_ENABLE:  nxt.run_flag = 1'b1;
            OP_DISABLE: nxt.run_flag = 1'b0;
            OP_TICK:
            begin
                if (cur.run_flag)
                begin
                    case (cur.phase)
                        PH_READY:
                        begin
                            nxt.trigger_out = 1'b1;
                            nxt.phase       = PH_TRIGGER;
                        end
                        PH_TRIGGER:
                        begin
                            nxt.trigger_out = 1'b0;
                            nxt.width_count = '0;
                            nxt.idle_count  = '0;
                            nxt.phase       = PH_WAITING;
                        end
                        PH_WAITING:
                        begin
                            if (echo_level)
                            begin
                                nxt.width_count = '0;
                                nxt.phase       = PH_RAISED;
                            end
                            else if (cur.idle_count >= cfg.idle_limit)
                            begin
                                // timeout: re-arm
                                nxt.idle_count = '0;
                                nxt.phase      = PH_READY;
                            end
                            else
                            begin
                                nxt.idle_count = cur.idle_count + 16'd1;
                            end
                        end
                        PH_RAISED:
                        begin
                            if (!echo_level || width_inc >= cfg.max_width)
                            begin
                                nxt.last_width    = width_inc;
                                nxt.width_count   = '0;
                                nxt.last_distance = calc_distance(width_inc,
                                                                  cfg.distance_offset);
                                nxt.phase         = PH_FINISHED;
                                nxt.run_flag      = 1'b0;
                                done              = 1'b1;
                            end
                            else
                            begin
                                nxt.width_count = width_inc;
                            end
                        end
                        default: nxt.phase = PH_READY;
                    endcase
                end
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

>>> src/ultrasonic_echo_ranger_unit.sv
// Top level of the ultrasonic echo ranger: state, config and result buffering.
`default_nettype none

// Ultrasonic echo ranger. Each beat on items is one microsecond tick (op tick)
// or an enable/disable command; each accepted beat yields exactly one beat on
// results, carrying the trigger pin level, a done pulse and the
// latest width/distance. One item is accepted every clock cycle: the sequencer
// update is a single pass of logic into the state registers, and the results
// side has an output register plus one skid entry, so items keeps flowing while
// one result waits; items.ready drops only when both entries are full. After a
// measurement the sequencer stops until an enable beat arrives. Configuration
// writes (idle_limit, max_width, distance_offset) take effect on the next beat.
module ultrasonic_echo_ranger_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [uer_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [uer_pkg::CFG_DATA_W-1:0]   cfg_data,
    uer_in_if.sink                           items,
    uer_out_if.source                        results
);
    import uer_pkg::*;

    uer_state_t  state_reg;
    uer_state_t  state_next;
    uer_cfg_t    cfg_reg;
    logic        step_done;
    uer_result_t res_next;

    logic        out_valid_reg;
    uer_result_t out_data_reg;
    logic        skid_valid_reg;
    uer_result_t skid_data_reg;

    logic        accept;
    logic        pop;

    uer_step u_step (
        .cur        (state_reg),
        .cfg        (cfg_reg),
        .op         (items.op),
        .echo_level (items.echo_level),
        .nxt        (state_next),
        .done       (step_done)
    );

    assign items.ready = !skid_valid_reg;
    assign accept      = items.valid && items.ready;
    assign pop         = results.valid && results.ready;

    always_comb
    begin
        res_next.trigger_level  = state_next.trigger_out;
        res_next.done_res       = step_done;
        res_next.distance       = state_next.last_distance;
        res_next.measured_width = state_next.last_width;
        res_next.running        = state_next.run_flag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.idle_limit      <= IDLE_LIMIT_RST;
            cfg_reg.max_width       <= MAX_WIDTH_RST;
            cfg_reg.distance_offset <= DISTANCE_OFFSET_RST;
        end
        else if (cfg_we)
        begin
            case (uer_cfg_idx_t'(cfg_index))
                CFG_IDLE_LIMIT:      cfg_reg.idle_limit      <= cfg_data;
                CFG_MAX_WIDTH:       cfg_reg.max_width       <= cfg_data[WIDTH_W-1:0];
                CFG_DISTANCE_OFFSET: cfg_reg.distance_offset <= cfg_data[WIDTH_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase         <= PH_START;
            state_reg.idle_count    <= '0;
            state_reg.width_count   <= '0;
            state_reg.last_width    <= '0;
            state_reg.last_distance <= '0;
            state_reg.trigger_out   <= 1'b0;
            state_reg.run_flag      <= 1'b1;
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

    // output register + skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (accept)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (accept)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_data_reg <= res_next;
            end
            else
            begin
                out_data_reg <= res_next;
            end
        end
    end

    assign results.valid          = out_valid_reg;
    assign results.trigger_level  = out_data_reg.trigger_level;
    assign results.done_res       = out_data_reg.done_res;
    assign results.distance       = out_data_reg.distance;
    assign results.measured_width = out_data_reg.measured_width;
    assign results.running        = out_data_reg.running;

endmodule

`default_nettype wire

>>> src/uer_checker.sv
// Port-level assertions for the echo ranger, bound to the top level.
`default_nettype none

module uer_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic        trigger_level,
    input logic        done_res,
    input logic [12:0] distance,
    input logic [9:0]  measured_width,
    input logic        running
);

    // a finished measurement always stops the sequencer
    a_done_stops: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res |-> !running)
        else $error("done beat with sequencer still running");

    // measurement ends in the echo phase, trigger is low by then
    a_done_trig_low: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res |-> !trigger_level)
        else $error("done beat with trigger high");

    // scaled width plus offset can never undercut the width itself
    a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (distance >= 13'(measured_width)) && (distance <= 13'd4501))
        else $error("distance inconsistent with measured width");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(distance) && $stable(done_res))
        else $error("stalled result beat changed");

endmodule

bind ultrasonic_echo_ranger_unit uer_checker u_uer_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (results.valid),
    .out_ready      (results.ready),
    .trigger_level  (results.trigger_level),
    .done_res       (results.done_res),
    .distance       (results.distance),
    .measured_width (results.measured_width),
    .running        (results.running)
);

`default_nettype wire
